FILE: rtl/core/ibld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibld_pkg: shared types and constants of the inline button ladder debouncer
// Widths of the sample, millivolt and threshold fields, button classes,
// register indexes and register reset values.
// ----------------------------------------------------------------------------
package ibld_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MV_W     = 26;
  localparam int unsigned QUOT_W   = 25;   // magnitude of 738 * sample
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned DIVS_W   = 15;   // magnitude of a positive gain
  localparam int unsigned TGT_W    = 12;
  localparam int unsigned BAND_W   = 10;
  localparam int unsigned LIM_W    = 4;
  localparam int unsigned CNT_W    = $clog2(QUOT_W);
  localparam int unsigned SCALE_W  = 10;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_DAT_W = 16;

  localparam logic [SCALE_W-1:0] MV_SCALE = 10'd738;

  typedef enum logic [1:0] {
    CLS_NONE     = 2'd0,
    CLS_CENTER   = 2'd1,
    CLS_VOL_UP   = 2'd2,
    CLS_VOL_DOWN = 2'd3
  } class_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLED     = 3'd0,
    REG_GAIN_K      = 3'd1,
    REG_CENTER_MV   = 3'd2,
    REG_VOL_UP_MV   = 3'd3,
    REG_VOL_DOWN_MV = 3'd4,
    REG_BAND_MV     = 3'd5,
    REG_DEB_LIMIT   = 3'd6
  } reg_idx_e;

  localparam logic [TGT_W-1:0]  CENTER_RST   = 12'd775;
  localparam logic [TGT_W-1:0]  VOL_UP_RST   = 12'd865;
  localparam logic [TGT_W-1:0]  VOL_DOWN_RST = 12'd938;
  localparam logic [BAND_W-1:0] BAND_RST     = 10'd35;
  localparam logic [LIM_W-1:0]  LIMIT_RST    = 4'd2;

  // Classifier and debounce settings
  typedef struct packed {
    logic [TGT_W-1:0]  center;
    logic [TGT_W-1:0]  vol_up;
    logic [TGT_W-1:0]  vol_down;
    logic [BAND_W-1:0] band;
    logic [LIM_W-1:0]  limit;
  } ibld_cfg_t;

endpackage

FILE: rtl/core/inline_button_ladder_debouncer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inline_button_ladder_debouncer_core: headset button decoder with debounce
// Converts an ADC poll to millivolts, classifies it and debounces the class.
// ----------------------------------------------------------------------------
// One poll is in work at a time. A valid poll runs the 25-step radix-2
// divider that forms 738*|sample|/gain, then the fix, class and done states;
// a poll seen while disabled or with non-positive gain goes straight to done.
// The result sits in an output register, so the next poll is taken while it
// waits; a stalled output holds the block at the end of the following poll.
// ----------------------------------------------------------------------------
module inline_button_ladder_debouncer_core import ibld_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [REG_DAT_W-1:0]     cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [SAMPLE_W-1:0] aux_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               pressed_o,
  output logic                     status_o,
  output logic signed [MV_W-1:0]   measured_mv_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_FIX   = 5'b00100,
    ST_CLASS = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic                   enabled_q;
  logic [GAIN_W-1:0]      gain_q;
  ibld_cfg_t              cfg_q;
  logic                   invalid_q;
  logic                   neg_q;
  logic signed [MV_W-1:0] mv_q;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             pressed_q;
  logic                   status_q;
  logic signed [MV_W-1:0] out_mv_q;

  logic                   in_xfer;
  logic                   invalid_now;
  logic [SAMPLE_W-1:0]    mag;
  logic [MV_W-1:0]        prod;
  logic                   div_start;
  logic                   div_done;
  logic [QUOT_W-1:0]      quot;
  logic                   out_free;
  logic                   load_out;
  logic                   commit;
  class_e                 press;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q      <= 1'b0;
      gain_q         <= '0;
      cfg_q.center   <= CENTER_RST;
      cfg_q.vol_up   <= VOL_UP_RST;
      cfg_q.vol_down <= VOL_DOWN_RST;
      cfg_q.band     <= BAND_RST;
      cfg_q.limit    <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLED:     enabled_q      <= cfg_wdata_i[0];
        REG_GAIN_K:      gain_q         <= cfg_wdata_i[GAIN_W-1:0];
        REG_CENTER_MV:   cfg_q.center   <= cfg_wdata_i[TGT_W-1:0];
        REG_VOL_UP_MV:   cfg_q.vol_up   <= cfg_wdata_i[TGT_W-1:0];
        REG_VOL_DOWN_MV: cfg_q.vol_down <= cfg_wdata_i[TGT_W-1:0];
        REG_BAND_MV:     cfg_q.band     <= cfg_wdata_i[BAND_W-1:0];
        REG_DEB_LIMIT:   cfg_q.limit    <= cfg_wdata_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign invalid_now = !enabled_q || gain_q[GAIN_W-1] || (gain_q == '0);

  assign mag  = aux_sample_i[SAMPLE_W-1] ? (~aux_sample_i + SAMPLE_W'(1))
                                         : aux_sample_i;
  assign prod = MV_W'(mag) * MV_W'(MV_SCALE);

  assign div_start = in_xfer && !invalid_now;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load_out  = (state_q == ST_DONE) && out_free;
  assign commit    = load_out && !invalid_q;

  ibld_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod[QUOT_W-1:0]),
    .divisor_i  (gain_q[DIVS_W-1:0]),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  ibld_class u_class (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .mv_i     (mv_q),
    .load_i   (state_q == ST_CLASS),
    .commit_i (commit),
    .press_o  (press)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = invalid_now ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX:   state_d = ST_CLASS;
      ST_CLASS: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item payload: sign and quotient, then the signed reading
  logic [QUOT_W-1:0] quot_hold_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      invalid_q <= invalid_now;
      neg_q     <= aux_sample_i[SAMPLE_W-1];
    end
    if (div_done) begin
      quot_hold_q <= quot;
    end
    if (state_q == ST_FIX) begin
      mv_q <= neg_q ? (MV_W'(0) - MV_W'(quot_hold_q)) : MV_W'(quot_hold_q);
    end
  end

  // Output register
  assign out_valid_d = load_out ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pressed_q <= invalid_q ? CLS_NONE : press;
      status_q  <= invalid_q;
      out_mv_q  <= invalid_q ? '0 : mv_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pressed_o     = pressed_q;
  assign status_o      = status_q;
  assign measured_mv_o = out_mv_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV)) else $error("divider done outside divide");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside done state");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (measured_mv_o == '0 && pressed_o == CLS_NONE))
    else $error("invalid result with nonzero payload");

endmodule

FILE: rtl/core/ibld_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibld_div: bit-serial restoring divider
// Shifts the dividend out of the top of a shift register and the quotient
// bits in at the bottom, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ibld_div import ibld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QUOT_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVS_W-1:0] rem_q;
  logic [QUOT_W-1:0] quot_q;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;
  logic              last;

  assign trial = {rem_q, quot_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};
  assign last  = (cnt_q == CNT_W'(QUOT_W - 1));

  assign done_o = busy_q && last;
  assign quot_o = {quot_q[QUOT_W-2:0], ge};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("divider still busy after done");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");

endmodule

FILE: rtl/core/ibld_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibld_class: button classifier and debounce state
// Registers the class of a millivolt reading, then advances the debounce
// state and reports a press when a new stable class is believed.
// ----------------------------------------------------------------------------
module ibld_class import ibld_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ibld_cfg_t              cfg_i,
  input  logic signed [MV_W-1:0] mv_i,
  input  logic                   load_i,
  input  logic                   commit_i,
  output class_e                 press_o
);

  class_e           cls_q, cls_d;
  class_e           stable_q, stable_d;
  class_e           pending_q, pending_d;
  logic [LIM_W-1:0] streak_q, streak_d;

  function automatic logic in_band(input logic signed [MV_W-1:0] mv,
                                   input logic [TGT_W-1:0] tgt,
                                   input logic [BAND_W-1:0] band);
    logic signed [MV_W-1:0] lo;
    logic signed [MV_W-1:0] hi;
    lo = $signed({{(MV_W-TGT_W){1'b0}}, tgt}) - $signed({{(MV_W-BAND_W){1'b0}}, band});
    hi = $signed({{(MV_W-TGT_W){1'b0}}, tgt}) + $signed({{(MV_W-BAND_W){1'b0}}, band});
    return (mv >= lo) && (mv <= hi);
  endfunction

  always_comb begin
    if (in_band(mv_i, cfg_i.center, cfg_i.band)) begin
      cls_d = CLS_CENTER;
    end else if (in_band(mv_i, cfg_i.vol_up, cfg_i.band)) begin
      cls_d = CLS_VOL_UP;
    end else if (in_band(mv_i, cfg_i.vol_down, cfg_i.band)) begin
      cls_d = CLS_VOL_DOWN;
    end else begin
      cls_d = CLS_NONE;
    end
  end

  always_comb begin
    stable_d  = stable_q;
    pending_d = pending_q;
    streak_d  = streak_q;
    press_o   = CLS_NONE;
    if (cls_q != pending_q) begin
      pending_d = cls_q;
      streak_d  = LIM_W'(1);
    end else if (streak_q < cfg_i.limit) begin
      streak_d = streak_q + LIM_W'(1);
    end else if (stable_q != pending_q) begin
      // a release reports none since pending is then none
      stable_d = pending_q;
      press_o  = pending_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cls_q <= cls_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= CLS_NONE;
      pending_q <= CLS_NONE;
      streak_q  <= '0;
    end else if (commit_i) begin
      stable_q  <= stable_d;
      pending_q <= pending_d;
      streak_q  <= streak_d;
    end
  end

endmodule
